// File: rtl/core/hncf_pkg.sv
// Shared types, codes and constants of the HCI notify and connection filter.
package hncf_pkg;

  localparam int unsigned MapEntriesDefault    = 8;
  localparam int unsigned MaxValueBytesDefault = 66;
  localparam int unsigned MaxDatagramDefault   = 4096;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned HeaderBytes = 6;

  localparam logic [15:0] PKT_EVENT   = 16'd3;
  localparam logic [15:0] PKT_ACL_RX  = 16'd5;
  localparam logic [7:0]  EVT_DISCONNECT = 8'h05;
  localparam logic [7:0]  EVT_LE_CONTROLLER = 8'h3e;
  localparam logic [7:0]  SUB_CONN       = 8'h01;
  localparam logic [7:0]  SUB_ENH_CONN   = 8'h0a;
  localparam logic [15:0] CID_ATT        = 16'h0004;
  localparam logic [7:0]  ATT_NOTIFY     = 8'h1b;
  localparam logic [15:0] ReportAttrReset = 16'h001a;

  typedef enum logic [1:0] {
    CFG_TARGET_ADDRESS   = 2'd0,
    CFG_TARGET_ENABLED   = 2'd1,
    CFG_REPORT_ATTRIBUTE = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    KIND_CONNECTED    = 3'd0,
    KIND_DISCONNECTED = 3'd1,
    KIND_BEGIN        = 3'd2,
    KIND_BYTE         = 3'd3,
    KIND_END          = 3'd4
  } kind_e;

  // All results caused by one input byte; at most one connected and one byte result.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][2:0] kinds;
    logic [47:0]     addr;
    logic            known;
    logic [7:0]      value;
  } entry_t;

endpackage

// File: rtl/core/hncf_front.sv
// Front part: datagram parser, connection map and announcement state.
module hncf_front #(
  parameter int unsigned MAP_ENTRIES     = hncf_pkg::MapEntriesDefault,
  parameter int unsigned MAX_VALUE_BYTES = hncf_pkg::MaxValueBytesDefault,
  parameter int unsigned MAX_DATAGRAM    = hncf_pkg::MaxDatagramDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [47:0]      cfg_data_i,
  input  logic             in_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_datagram_i,
  output hncf_pkg::entry_t entry_o,
  output logic             entry_valid_o
);

  localparam int unsigned PosW = $clog2(MAX_DATAGRAM + 1);
  localparam int unsigned CntW = $clog2(MAX_VALUE_BYTES + 1);
  localparam int unsigned MapW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  logic [47:0] target_q;
  logic        target_en_q;
  logic [15:0] report_attr_q;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0] ptype_q, ptype_d, dlen_q, dlen_d, header_q, header_d;
  logic [47:0] fields_q, fields_d, peer_q, peer_d;
  logic [63:0] acl_q, acl_d;
  logic        notify_q, notify_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        ann_valid_q, ann_valid_d;
  logic [15:0] ann_handle_q, ann_handle_d;

  logic [15:0] map_handle_q [MAP_ENTRIES];
  logic [47:0] map_addr_q   [MAP_ENTRIES];

  logic            store_en;
  logic [15:0]     store_handle;
  logic [47:0]     store_addr;
  logic [MapW-1:0] store_slot;
  logic [15:0]     lookup_handle;
  logic            lookup_hit;
  logic [47:0]     lookup_addr;

  // Slot for a new connection: first with the same handle or empty, else slot zero.
  always_comb begin
    logic found;
    found      = 1'b0;
    store_slot = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (!found && (map_handle_q[i] == store_handle || map_handle_q[i] == 16'd0)) begin
        found      = 1'b1;
        store_slot = MapW'(i);
      end
    end
  end

  always_comb begin
    lookup_hit  = 1'b0;
    lookup_addr = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (!lookup_hit && map_handle_q[i] == lookup_handle) begin
        lookup_hit  = 1'b1;
        lookup_addr = map_addr_q[i];
      end
    end
  end

  always_comb begin
    logic [15:0] idx;
    logic [2:0]  fsel;
    logic [1:0]  n;
    hncf_pkg::entry_t ent;
    idx  = 16'(pos_q) - 16'(hncf_pkg::HeaderBytes);
    fsel = 3'(idx - 16'd2);
    n    = '0;
    ent  = '0;
    pos_d = pos_q;  ptype_d = ptype_q;  dlen_d = dlen_q;  header_d = header_q;
    fields_d = fields_q;  peer_d = peer_q;  acl_d = acl_q;
    notify_d = notify_q;  cnt_d = cnt_q;
    ann_valid_d = ann_valid_q;  ann_handle_d = ann_handle_q;
    store_en = 1'b0;
    store_handle = fields_q[31:16];
    store_addr = {data_byte_i, peer_q[39:0]};
    lookup_handle = {4'd0, acl_q[11:0]};

    if (in_valid_i) begin
      if (pos_q < PosW'(MAX_DATAGRAM)) begin
        pos_d = pos_q + PosW'(1);
        if (pos_q < PosW'(2)) begin
          ptype_d[{pos_q[0], 3'b000} +: 8] = data_byte_i;
        end else if (pos_q >= PosW'(4) && pos_q < PosW'(6)) begin
          dlen_d[{pos_q[0], 3'b000} +: 8] = data_byte_i;
        end else if (pos_q >= PosW'(6) && idx < dlen_q) begin
          if (ptype_q == hncf_pkg::PKT_EVENT) begin
            if (idx < 16'd2) begin
              header_d[{idx[0], 3'b000} +: 8] = data_byte_i;
            end else begin
              if (idx < 16'd8) fields_d[{fsel, 3'b000} +: 8] = data_byte_i;
              else if (idx < 16'd14) peer_d[{fsel - 3'd6, 3'b000} +: 8] = data_byte_i;
              if (idx == 16'd4 && header_q[7:0] == hncf_pkg::EVT_DISCONNECT &&
                  header_q[15:8] >= 8'd3 && ann_valid_q &&
                  {data_byte_i, fields_q[15:8]} == ann_handle_q) begin
                ann_valid_d = 1'b0;
                ent.kinds[n] = hncf_pkg::KIND_DISCONNECTED;
                n = n + 2'd1;
              end
              if (idx == 16'd13 && header_q[7:0] == hncf_pkg::EVT_LE_CONTROLLER &&
                  header_q[15:8] >= 8'd12 && fields_q[15:8] == 8'd0 &&
                  (fields_q[7:0] == hncf_pkg::SUB_CONN ||
                   fields_q[7:0] == hncf_pkg::SUB_ENH_CONN)) begin
                store_en = 1'b1;
                // The stored slot is also the one a lookup finds, so the address is known.
                if (target_en_q && store_addr == target_q && !ann_valid_q) begin
                  ann_valid_d  = 1'b1;
                  ann_handle_d = fields_q[31:16];
                  ent.kinds[n] = hncf_pkg::KIND_CONNECTED;
                  ent.addr     = store_addr;
                  ent.known    = 1'b1;
                  n = n + 2'd1;
                end
              end
            end
          end else if (ptype_q == hncf_pkg::PKT_ACL_RX) begin
            if (idx < 16'd8) begin
              acl_d[{idx[2:0], 3'b000} +: 8] = data_byte_i;
            end else if (idx < 16'd10) begin
              header_d[{idx[0], 3'b000} +: 8] = data_byte_i;
            end else if (idx == 16'd10) begin
              if (acl_q[63:48] == hncf_pkg::CID_ATT && header_q[7:0] == hncf_pkg::ATT_NOTIFY &&
                  {data_byte_i, header_q[15:8]} == report_attr_q) begin
                if (!ann_valid_q || lookup_handle == ann_handle_q) begin
                  if (!ann_valid_q) begin
                    ann_valid_d  = 1'b1;
                    ann_handle_d = lookup_handle;
                    ent.kinds[n] = hncf_pkg::KIND_CONNECTED;
                    ent.addr     = lookup_addr;
                    ent.known    = lookup_hit;
                    n = n + 2'd1;
                  end
                  notify_d = 1'b1;
                  cnt_d    = '0;
                  ent.kinds[n] = hncf_pkg::KIND_BEGIN;
                  n = n + 2'd1;
                end
              end
            end else if (notify_q && cnt_q < CntW'(MAX_VALUE_BYTES)) begin
              cnt_d = cnt_q + CntW'(1);
              ent.kinds[n] = hncf_pkg::KIND_BYTE;
              ent.value    = data_byte_i;
              n = n + 2'd1;
            end
          end
        end
      end
      if (end_of_datagram_i) begin
        if (notify_d) begin
          ent.kinds[n] = hncf_pkg::KIND_END;
          n = n + 2'd1;
        end
        pos_d = '0;  ptype_d = '0;  dlen_d = '0;  header_d = '0;
        fields_d = '0;  peer_d = '0;  acl_d = '0;  notify_d = 1'b0;  cnt_d = '0;
      end
    end
    ent.count     = n;
    entry_o       = ent;
    entry_valid_o = in_valid_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;  target_en_q <= 1'b0;  report_attr_q <= hncf_pkg::ReportAttrReset;
      pos_q <= '0;  ptype_q <= '0;  dlen_q <= '0;  header_q <= '0;
      fields_q <= '0;  peer_q <= '0;  acl_q <= '0;  notify_q <= 1'b0;  cnt_q <= '0;
      ann_valid_q <= 1'b0;  ann_handle_q <= '0;
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        map_handle_q[i] <= '0;
        map_addr_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          hncf_pkg::CFG_TARGET_ADDRESS:   target_q      <= cfg_data_i;
          hncf_pkg::CFG_TARGET_ENABLED:   target_en_q   <= cfg_data_i[0];
          hncf_pkg::CFG_REPORT_ATTRIBUTE: report_attr_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      pos_q <= pos_d;  ptype_q <= ptype_d;  dlen_q <= dlen_d;  header_q <= header_d;
      fields_q <= fields_d;  peer_q <= peer_d;  acl_q <= acl_d;
      notify_q <= notify_d;  cnt_q <= cnt_d;
      ann_valid_q <= ann_valid_d;  ann_handle_q <= ann_handle_d;
      if (store_en) begin
        map_handle_q[store_slot] <= store_handle;
        map_addr_q[store_slot]   <= store_addr;
      end
    end
  end

endmodule

// File: rtl/core/hncf_queue.sv
// Short queue of per-byte result groups between the parser and the emitter.
module hncf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hncf_pkg::entry_t push_data_i,
  input  logic             pop_i,
  output hncf_pkg::entry_t pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(hncf_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(hncf_pkg::QueueDepth + 1);

  hncf_pkg::entry_t mem_q [hncf_pkg::QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o     = (count_q == CntW'(hncf_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;  rptr_q <= '0;  count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= rptr_q + PtrW'(1);
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue request pushed while full");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(hncf_pkg::QueueDepth)) else $error("queue count overflow");
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> !empty_o) else $error("queue lost a request");
  a_pushed_groups_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |-> push_data_i.count != 2'd0) else $error("empty result group queued");
`endif

endmodule

// File: rtl/core/hncf_back.sv
// Back part: holds one result group and hands its results out one per request.
module hncf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hncf_pkg::entry_t q_data_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [2:0]       kind_o,
  output logic [47:0]      peer_address_o,
  output logic             address_known_o,
  output logic [7:0]       value_byte_o,
  output logic             run_last_o
);

  hncf_pkg::entry_t ent_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       last, load;
  logic [2:0] kind;

  assign kind            = ent_q.kinds[idx_q];
  assign last            = (idx_q == ent_q.count - 2'd1);
  assign empty_o         = !valid_q;
  assign kind_o          = kind;
  assign peer_address_o  = (kind == hncf_pkg::KIND_CONNECTED) ? ent_q.addr : '0;
  assign address_known_o = (kind == hncf_pkg::KIND_CONNECTED) && ent_q.known;
  assign value_byte_o    = (kind == hncf_pkg::KIND_BYTE) ? ent_q.value : '0;
  assign run_last_o      = last;
  assign load            = !valid_q || (pop_i && last);
  assign q_pop_o         = load && !q_empty_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) ent_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= !q_empty_i;
      idx_q   <= '0;
    end else if (pop_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// File: rtl/core/hci_notify_connection_filter_unit.sv
// Top level of the HCI notify and connection filter.
//
//  Channel   Handshake          Payload
//  input     push_i / full_o    data_byte_i, end_of_datagram_i
//  result    empty_o / pop_i    kind_o, peer_address_o, address_known_o,
//                               value_byte_o, run_last_o
//  config    cfg_we_i           cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while the four-entry group queue has room.
// Each byte yields up to three results; the emitter gives one per cycle
// while pop_i is high, so a byte with several results keeps it busy until
// the last is popped. A result reaches the ports through the group queue
// and the emitter's holding register; it can be popped at the following edge.
// Reset clears the map, announcement and parser; stalls on the result
// side fill the queue and then raise full_o.
module hci_notify_connection_filter_unit #(
  parameter int unsigned MAP_ENTRIES     = hncf_pkg::MapEntriesDefault,
  parameter int unsigned MAX_VALUE_BYTES = hncf_pkg::MaxValueBytesDefault,
  parameter int unsigned MAX_DATAGRAM    = hncf_pkg::MaxDatagramDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_datagram_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  kind_o,
  output logic [47:0] peer_address_o,
  output logic        address_known_o,
  output logic [7:0]  value_byte_o,
  output logic        run_last_o
);

  hncf_pkg::entry_t front_entry, q_data;
  logic front_valid, q_full, q_empty, q_pop;

  assign full_o = q_full;

  hncf_front #(
    .MAP_ENTRIES(MAP_ENTRIES),
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES),
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i(push_i && !q_full),
    .data_byte_i, .end_of_datagram_i,
    .entry_o(front_entry),
    .entry_valid_o(front_valid)
  );

  hncf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(front_valid),
    .push_data_i(front_entry),
    .pop_i(q_pop),
    .pop_data_o(q_data),
    .full_o(q_full),
    .empty_o(q_empty)
  );

  hncf_back u_back (
    .clk_i, .rst_ni,
    .q_data_i(q_data),
    .q_empty_i(q_empty),
    .q_pop_o(q_pop),
    .pop_i, .empty_o, .kind_o, .peer_address_o, .address_known_o,
    .value_byte_o, .run_last_o
  );

endmodule

// File: test/tb_hci_notify_connection_filter_unit.sv
// Self-checking testbench of the HCI notify and connection filter with a predicting scoreboard.
module tb_hci_notify_connection_filter_unit;
  import hncf_pkg::*;

  // Predicts the results of each accepted byte and checks what the block returns.
  class filter_scoreboard;
    typedef struct {
      kind_e       kind;
      logic [47:0] addr;
      logic        known;
      logic [7:0]  value;
      logic        last;
    } result_t;

    result_t     pending[$];
    bit          failed;
    logic [47:0] tgt_addr = '0;
    bit          tgt_en;
    logic [15:0] rpt_attr = ReportAttrReset;
    int          pos;
    logic [15:0] ptype = '0, dlen = '0, evh = '0;
    logic [47:0] evf = '0, evp = '0;
    logic [63:0] aclf = '0;
    bit          nact;
    int          ncount;
    bit          ann_valid;
    logic [15:0] ann_handle = '0;
    logic [15:0] map_h[MapEntriesDefault] = '{default: '0};
    logic [47:0] map_a[MapEntriesDefault] = '{default: '0};
    result_t     step_res[$];

    function void configure(cfg_index_e idx, logic [47:0] data);
      case (idx)
        CFG_TARGET_ADDRESS:   tgt_addr = data;
        CFG_TARGET_ENABLED:   tgt_en = data[0];
        CFG_REPORT_ATTRIBUTE: rpt_attr = data[15:0];
        default: ;
      endcase
    endfunction

    function void add(kind_e k, logic [47:0] a, logic kn, logic [7:0] v);
      result_t r;
      r.kind = k; r.addr = a; r.known = kn; r.value = v; r.last = 1'b0;
      step_res.push_back(r);
    endfunction

    function void store_conn(logic [15:0] h, logic [47:0] a);
      for (int i = 0; i < MapEntriesDefault; i++) begin
        if (map_h[i] == h || map_h[i] == 16'd0) begin
          map_h[i] = h; map_a[i] = a;
          return;
        end
      end
      map_h[0] = h; map_a[0] = a;
    endfunction

    function void announce(logic [15:0] h);
      logic [47:0] a;
      logic kn;
      a = '0; kn = 1'b0;
      ann_valid = 1'b1;
      ann_handle = h;
      for (int i = 0; i < MapEntriesDefault; i++) begin
        if (map_h[i] == h) begin
          a = map_a[i]; kn = 1'b1;
          break;
        end
      end
      add(KIND_CONNECTED, a, kn, 8'd0);
    endfunction

    function void event_data(int idx, logic [7:0] b);
      logic [7:0] code, plen;
      code = evh[7:0];
      plen = evh[15:8];
      if (idx < 2) begin
        evh |= 16'(b) << (8 * idx);
        return;
      end
      if (idx < 8) evf |= 48'(b) << (8 * (idx - 2));
      else if (idx < 14) evp |= 48'(b) << (8 * (idx - 8));
      if (idx == 4 && code == EVT_DISCONNECT && plen >= 3) begin
        if (ann_valid && evf[23:8] == ann_handle) begin
          ann_valid = 1'b0;
          add(KIND_DISCONNECTED, '0, 1'b0, 8'd0);
        end
      end
      if (idx == 13 && code == EVT_LE_CONTROLLER && plen >= 12) begin
        if ((evf[7:0] == SUB_CONN || evf[7:0] == SUB_ENH_CONN) && evf[15:8] == 8'd0) begin
          store_conn(evf[31:16], evp);
          if (tgt_en && evp == tgt_addr && !ann_valid) announce(evf[31:16]);
        end
      end
    endfunction

    function void acl_data(int idx, logic [7:0] b);
      logic [15:0] h;
      if (idx < 8) begin
        aclf |= 64'(b) << (8 * idx);
        return;
      end
      if (idx < 10) begin
        evh |= 16'(b) << (8 * (idx - 8));
        return;
      end
      if (idx == 10) begin
        h = {4'd0, aclf[11:0]};
        if (aclf[63:48] != CID_ATT || evh[7:0] != ATT_NOTIFY || {b, evh[15:8]} != rpt_attr)
          return;
        if (!ann_valid) announce(h);
        else if (h != ann_handle) return;
        nact = 1'b1;
        ncount = 0;
        add(KIND_BEGIN, '0, 1'b0, 8'd0);
        return;
      end
      if (nact && ncount < MaxValueBytesDefault) begin
        ncount++;
        add(KIND_BYTE, '0, 1'b0, b);
      end
    endfunction

    // Called once per accepted input request.
    function void note_byte(logic [7:0] b, logic eod);
      step_res.delete();
      if (pos < MaxDatagramDefault) begin
        if (pos < 2) ptype |= 16'(b) << (8 * pos);
        else if (pos >= 4 && pos < 6) dlen |= 16'(b) << (8 * (pos - 4));
        else if (pos >= 6 && pos - 6 < dlen) begin
          if (ptype == PKT_EVENT) event_data(pos - 6, b);
          else if (ptype == PKT_ACL_RX) acl_data(pos - 6, b);
        end
        pos++;
      end
      if (eod) begin
        if (nact) add(KIND_END, '0, 1'b0, 8'd0);
        pos = 0; ptype = '0; dlen = '0; evh = '0; evf = '0; evp = '0; aclf = '0;
        nact = 1'b0; ncount = 0;
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
      foreach (step_res[i]) pending.push_back(step_res[i]);
    endfunction

    function void check(logic [2:0] k, logic [47:0] a, logic kn, logic [7:0] v, logic l);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, k);
        failed = 1'b1;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
        failed = 1'b1;
      end
      if (a !== e.addr) begin
        $display("%0t: peer_address expected %h actual %h", $time, e.addr, a);
        failed = 1'b1;
      end
      if (kn !== e.known) begin
        $display("%0t: address_known expected %b actual %b", $time, e.known, kn);
        failed = 1'b1;
      end
      if (v !== e.value) begin
        $display("%0t: value_byte expected %h actual %h", $time, e.value, v);
        failed = 1'b1;
      end
      if (l !== e.last) begin
        $display("%0t: run_last expected %b actual %b", $time, e.last, l);
        failed = 1'b1;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [47:0] cfg_data_i;
  logic        push_i, full_o;
  logic [7:0]  data_byte_i;
  logic        end_of_datagram_i;
  logic        empty_o, pop_i;
  logic [2:0]  kind_o;
  logic [47:0] peer_address_o;
  logic        address_known_o;
  logic [7:0]  value_byte_o;
  logic        run_last_o;

  hci_notify_connection_filter_unit DUT (.*);

  filter_scoreboard sb = new;
  logic [7:0]  pkt_body[$];
  logic [15:0] handle_pool[4];
  int          bytes_sent;
  bit          hold_req;
  bit          no_idle;
  int          quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = CFG_TARGET_ADDRESS; cfg_data_i = '0;
    push_i = 1'b0; data_byte_i = '0; end_of_datagram_i = 1'b0;
    pop_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic send_byte(logic [7:0] b, logic eod);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    data_byte_i <= b;
    end_of_datagram_i <= eod;
    do @(posedge clk_i); while (full_o);
    sb.note_byte(b, eod);
    bytes_sent++;
  endtask

  // Sends a monitor datagram; declared length and real length may be cut.
  task automatic send_pkt(logic [15:0] ptype, int dlen, int cut);
    logic [7:0] hdr[6];
    int total;
    hdr = '{ptype[7:0], ptype[15:8], 8'($urandom), 8'($urandom), dlen[7:0], dlen[15:8]};
    total = 6 + pkt_body.size() - cut;
    for (int i = 0; i < total; i++)
      send_byte(i < 6 ? hdr[i] : pkt_body[i - 6], i == total - 1);
  endtask

  task automatic send_framed(logic [15:0] ptype);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) send_pkt(ptype, $urandom_range(0, pkt_body.size()), 0);
    else if (r == 1) send_pkt(ptype, pkt_body.size(), $urandom_range(0, pkt_body.size()));
    else if (r == 2) send_pkt(ptype, 16'hffff, 0);
    else send_pkt(ptype, pkt_body.size(), 0);
  endtask

  function automatic void build_conn(logic [7:0] sub, logic [7:0] status, logic [15:0] h,
                                     logic [47:0] peer);
    pkt_body.delete();
    pkt_body = '{EVT_LE_CONTROLLER, (sub == SUB_ENH_CONN) ? 8'd30 : 8'd18, sub, status,
                 h[7:0], h[15:8], 8'($urandom), 8'($urandom)};
    for (int i = 0; i < 6; i++) pkt_body.push_back(peer[8 * i +: 8]);
    repeat ((sub == SUB_ENH_CONN) ? 18 : 6) pkt_body.push_back(8'($urandom));
  endfunction

  function automatic void build_disc(logic [15:0] h);
    pkt_body.delete();
    pkt_body = '{EVT_DISCONNECT, 8'd4, 8'd0, h[7:0], h[15:8], 8'($urandom)};
  endfunction

  function automatic void build_notify(logic [11:0] h, logic [15:0] attr, int nval);
    pkt_body.delete();
    pkt_body = '{h[7:0], {4'($urandom), h[11:8]}, 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), CID_ATT[7:0], CID_ATT[15:8],
                 ATT_NOTIFY, attr[7:0], attr[15:8]};
    repeat (nval) pkt_body.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_handle();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : handle_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [47:0] pick_peer();
    return ($urandom_range(0, 2) == 0) ? {16'($urandom), 32'($urandom)} : sb.tgt_addr;
  endfunction

  function automatic int pick_count();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 8);
  endfunction

  task automatic random_datagram();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      build_conn($urandom_range(0, 1) ? SUB_CONN : SUB_ENH_CONN,
                 ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd0, pick_handle(), pick_peer());
      if ($urandom_range(0, 9) == 0) pkt_body[$urandom_range(0, 2)] = 8'($urandom);
      send_framed(PKT_EVENT);
    end else if (r < 40) begin
      build_disc(pick_handle());
      if ($urandom_range(0, 9) == 0) pkt_body[$urandom_range(0, 1)] = 8'($urandom);
      send_framed(PKT_EVENT);
    end else if (r < 85) begin
      build_notify(12'(pick_handle()),
                   ($urandom_range(0, 7) == 0) ? 16'($urandom) : sb.rpt_attr, pick_count());
      if ($urandom_range(0, 9) == 0) pkt_body[$urandom_range(6, 8)] = 8'($urandom);
      send_framed($urandom_range(0, 19) == 0 ? PKT_EVENT : PKT_ACL_RX);
    end else begin
      pkt_body.delete();
      repeat ($urandom_range(0, 20)) pkt_body.push_back(8'($urandom));
      send_pkt(16'($urandom_range(0, 7)), $urandom_range(0, 30), 0);
    end
  endtask

  task automatic wait_idle();
    push_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_index_e idx, logic [47:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.configure(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: pops with random gaps and holds off for a long stretch when hold_req is set.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
      sb.check(kind_o, peer_address_o, address_known_o, value_byte_o, run_last_o);
    end
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int target;
    quiet_cycles = 0;
    foreach (handle_pool[i]) handle_pool[i] = (i == 0) ? 16'd0 : 16'($urandom_range(1, 4095));
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: connect, notify on a known handle, long value, disconnect.
    build_conn(SUB_CONN, 8'd0, 16'd5, 48'h0000_0000_0001);
    send_pkt(PKT_EVENT, pkt_body.size(), 0);
    build_notify(12'd5, ReportAttrReset, 3);
    send_pkt(PKT_ACL_RX, pkt_body.size(), 0);
    build_notify(12'd7, ReportAttrReset, 2);
    send_pkt(PKT_ACL_RX, pkt_body.size(), 0);
    // The receiver holds off while the long value streams in, so the queue fills.
    hold_req = 1'b1;
    build_notify(12'd5, ReportAttrReset, 70);
    send_pkt(PKT_ACL_RX, pkt_body.size(), 0);
    build_disc(16'd5);
    send_pkt(PKT_EVENT, pkt_body.size(), 0);
    // Handle zero hits an empty slot.
    build_notify(12'd0, ReportAttrReset, 1);
    send_pkt(PKT_ACL_RX, pkt_body.size(), 0);
    build_disc(16'd0);
    send_pkt(PKT_EVENT, pkt_body.size(), 0);
    // Short datagram and a cut one.
    build_notify(12'd9, ReportAttrReset, 4);
    send_pkt(PKT_ACL_RX, 10, 0);
    send_pkt(PKT_ACL_RX, pkt_body.size(), 5);
    build_disc(16'd9);
    send_pkt(PKT_EVENT, pkt_body.size(), 0);

    target = bytes_sent;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        1: begin
          cfg_write(CFG_TARGET_ADDRESS, 48'd0);
          cfg_write(CFG_TARGET_ENABLED, 48'd1);
          cfg_write(CFG_REPORT_ATTRIBUTE, 48'(ReportAttrReset));
        end
        2: begin
          cfg_write(CFG_TARGET_ADDRESS, 48'hffff_ffff_ffff);
          cfg_write(CFG_REPORT_ATTRIBUTE, 48'hffff);
        end
        3: begin
          cfg_write(CFG_TARGET_ADDRESS, {16'($urandom), 32'($urandom)});
          cfg_write(CFG_TARGET_ENABLED, 48'd0);
          cfg_write(CFG_REPORT_ATTRIBUTE, 48'd0);
        end
        4: begin
          cfg_write(CFG_TARGET_ADDRESS, {16'($urandom), 32'($urandom)});
          cfg_write(CFG_TARGET_ENABLED, 48'd1);
          cfg_write(CFG_REPORT_ATTRIBUTE, 48'($urandom_range(0, 65535)));
        end
        default: ;
      endcase
      target += 12;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
        random_datagram();
      end
      no_idle = 1'b0;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (!sb.failed && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
